@@ design/ps2r_pkg.sv @@
`default_nettype none

package ps2r_pkg;

    // FIFO depth default (usable capacity is depth minus one)
    localparam int FIFO_DEPTH_DEF = 64;

    localparam int CODE_W    = 8;
    localparam int TIMEOUT_W = 16;
    localparam int IDLE_W    = 17;
    localparam int COUNT_W   = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd250;
    localparam logic [COUNT_W-1:0]   FRAME_BITS      = 4'd11;
    localparam logic [COUNT_W-1:0]   LAST_DATA_INDEX = 4'd7;
    localparam logic [IDLE_W-1:0]    IDLE_MAX        = 17'h1FFFF;

    // Request codes; code 3 is unused and answers with an all-zero beat
    typedef enum logic [1:0] {
        REQ_EDGE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_POP  = 2'd2
    } t_req;

    // Per-item status carried from the receiver to the output pipeline
    typedef struct packed {
        logic code_valid;
        logic frame_done;
        logic frame_dropped;
    } t_item_info;

endpackage

`default_nettype wire

@@ design/ps2r_req_if.sv @@
`default_nettype none

interface ps2r_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       data_bit;

    modport source (output valid, output req_type, output data_bit, input ready);
    modport sink   (input valid, input req_type, input data_bit, output ready);
endinterface

`default_nettype wire

@@ design/ps2r_res_if.sv @@
`default_nettype none

interface ps2r_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;
    logic       code_valid;
    logic       frame_done;
    logic       frame_dropped;

    modport source (output valid, output scan_code, output code_valid,
                    output frame_done, output frame_dropped, input ready);
    modport sink   (input valid, input scan_code, input code_valid,
                    input frame_done, input frame_dropped, output ready);
endinterface

`default_nettype wire

@@ design/ps2r_ram.sv @@
`default_nettype none

module ps2r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/ps2r_rx.sv @@
`default_nettype none

// Frame assembly, idle timer and FIFO pointers. State commits on each accepted beat.
module ps2r_rx #(
    parameter int FIFO_DEPTH = ps2r_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [ps2r_pkg::TIMEOUT_W-1:0]       i_cfg_wr_data,
    input  wire logic                                 i_accept,
    input  wire logic [1:0]                           i_req_type,
    input  wire logic                                 i_data_bit,
    output ps2r_pkg::t_item_info                      o_info,
    output logic                                      o_ram_wr_en,
    output logic      [$clog2(FIFO_DEPTH)-1:0]        o_ram_wr_addr,
    output logic      [ps2r_pkg::CODE_W-1:0]          o_ram_wr_data,
    output logic                                      o_ram_rd_en,
    output logic      [$clog2(FIFO_DEPTH)-1:0]        o_ram_rd_addr
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [ps2r_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [ps2r_pkg::COUNT_W-1:0]   r_bit_count, n_bit_count;
    logic [ps2r_pkg::CODE_W-1:0]    r_shift_byte, n_shift_byte;
    logic [ps2r_pkg::IDLE_W-1:0]    r_idle, n_idle;
    logic [PTR_W-1:0]               r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]               r_rd_ptr, n_rd_ptr;

    logic [PTR_W-1:0]               wr_next, rd_next;
    logic                           timed_out;
    logic [ps2r_pkg::COUNT_W-1:0]   edge_count;
    logic [ps2r_pkg::CODE_W-1:0]    edge_byte;
    logic                           wr_req, rd_req;
    ps2r_pkg::t_item_info           info;

    // ring successors
    assign wr_next = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    // stale partial frame after a long idle gap
    assign timed_out = r_idle > {1'b0, r_timeout};

    // next state and per-item status
    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift_byte = r_shift_byte;
        n_idle       = r_idle;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        edge_count   = timed_out ? '0 : r_bit_count;
        edge_byte    = timed_out ? '0 : r_shift_byte;
        wr_req       = 1'b0;
        rd_req       = 1'b0;
        info         = '0;
        unique case (ps2r_pkg::t_req'(i_req_type))
            ps2r_pkg::REQ_EDGE: begin
                n_idle = '0;
                // data bits land LSB first on edges two to nine
                if (edge_count >= 4'd1 && edge_count <= ps2r_pkg::LAST_DATA_INDEX + 4'd1) begin
                    edge_byte = edge_byte
                              | (ps2r_pkg::CODE_W'(i_data_bit) << 3'(edge_count - 4'd1));
                end
                edge_count = edge_count + 4'd1;
                if (edge_count == ps2r_pkg::FRAME_BITS) begin
                    info.frame_done = 1'b1;
                    if (wr_next != r_rd_ptr) begin
                        wr_req   = 1'b1;
                        n_wr_ptr = wr_next;
                    end else begin
                        info.frame_dropped = 1'b1;
                    end
                    n_bit_count  = '0;
                    n_shift_byte = '0;
                end else begin
                    n_bit_count  = edge_count;
                    n_shift_byte = edge_byte;
                end
            end
            ps2r_pkg::REQ_TICK: begin
                if (r_idle != ps2r_pkg::IDLE_MAX) begin
                    n_idle = r_idle + 1'b1;
                end
            end
            ps2r_pkg::REQ_POP: begin
                if (r_rd_ptr != r_wr_ptr) begin
                    rd_req          = 1'b1;
                    info.code_valid = 1'b1;
                    n_rd_ptr        = rd_next;
                end
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= ps2r_pkg::TIMEOUT_RESET;
            r_bit_count  <= '0;
            r_shift_byte <= '0;
            r_idle       <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_bit_count  <= n_bit_count;
                r_shift_byte <= n_shift_byte;
                r_idle       <= n_idle;
                r_wr_ptr     <= n_wr_ptr;
                r_rd_ptr     <= n_rd_ptr;
            end
        end
    end

    assign o_info        = info;
    assign o_ram_wr_en   = i_accept && wr_req;
    assign o_ram_wr_addr = wr_next;
    assign o_ram_wr_data = edge_byte;
    assign o_ram_rd_en   = i_accept && rd_req;
    assign o_ram_rd_addr = rd_next;

    // pointers never leave the ring
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr <= PTR_LAST && r_rd_ptr <= PTR_LAST)
        else $error("fifo pointer out of range");

    // a frame never stops past its last bit
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < ps2r_pkg::FRAME_BITS)
        else $error("bit count past frame length");

endmodule

`default_nettype wire

@@ design/ps2_frame_receiver_fifo_top.sv @@
`default_nettype none

// Channel  | Dir | Beat payload
// ---------+-----+-------------------------------------------------------
// i_req    | in  | req_type (edge / tick / pop), data_bit
// o_res    | out | scan_code, code_valid, frame_done, frame_dropped
// i_cfg_*  | in  | timeout_ticks, written when i_cfg_wr_en is high
//
// One beat per cycle sustained while o_res.ready stays high; every request beat yields one result beat.
// Receiver state and the FIFO RAM read commit on the accept edge; the RAM read data
// joins the stage 1 status in the stage 2 output register when stage 1 moves on.
// i_rst_n is synchronous; the FIFO RAM has no clearing pass (pointers guard it).
// A stalled output holds both stages; i_req.ready drops only when both are full.
module ps2_frame_receiver_fifo_top #(
    parameter int FIFO_DEPTH = ps2r_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ps2r_pkg::TIMEOUT_W-1:0] i_cfg_wr_data,
    ps2r_req_if.sink                            i_req,
    ps2r_res_if.source                          o_res
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic                          in_accept;
    logic                          s1_move;
    ps2r_pkg::t_item_info          info;
    logic                          ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]              ram_wr_addr, ram_rd_addr;
    logic [ps2r_pkg::CODE_W-1:0]   ram_wr_data, ram_rd_data;

    logic                          r_s1_valid;
    ps2r_pkg::t_item_info          r_s1_info;
    logic                          r_s2_valid;
    ps2r_pkg::t_item_info          r_s2_info;
    logic [ps2r_pkg::CODE_W-1:0]   r_s2_code;

    // pipeline flow
    assign s1_move     = r_s1_valid && (!r_s2_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign in_accept   = i_req.valid && i_req.ready;

    ps2r_rx #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_req_type    (i_req.req_type),
        .i_data_bit    (i_req.data_bit),
        .o_info        (info),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr)
    );

    ps2r_ram #(
        .WIDTH (ps2r_pkg::CODE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // stage 1: status waits for the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_info <= info;
        end
    end

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_info <= r_s1_info;
            r_s2_code <= r_s1_info.code_valid ? ram_rd_data : '0;
        end
    end

    assign o_res.valid         = r_s2_valid;
    assign o_res.scan_code     = r_s2_code;
    assign o_res.code_valid    = r_s2_info.code_valid;
    assign o_res.frame_done    = r_s2_info.frame_done;
    assign o_res.frame_dropped = r_s2_info.frame_dropped;

    // a drop is always part of a finished frame, never of a pop
    a_drop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_dropped |-> o_res.frame_done && !o_res.code_valid)
        else $error("drop without completed frame");

    // no code leaks out on a beat that popped nothing
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.code_valid |-> o_res.scan_code == '0)
        else $error("scan code without valid pop");

    // a blocked stage 1 keeps its beat
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_info))
        else $error("stage 1 beat lost under stall");

    // a RAM read only happens when stage 1 is free to take its data
    a_rd_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_rd_en |-> !r_s1_valid || s1_move)
        else $error("RAM read overwrote pending data");

endmodule

`default_nettype wire
